// ----- rtl/core/vfao_pkg.sv -----
// ---------------------------------------------------------------------------
// vfao_pkg
// shared types, index tables and constants for the voxel face ao unit
// ---------------------------------------------------------------------------
package vfao_pkg;

   localparam int NUM_VOXELS   = 27;
   localparam int NUM_FACES    = 6;
   localparam int NUM_CORNERS  = 4;
   localparam int VOXEL_W      = 5;
   localparam int FACE_W       = 3;
   localparam int CORNER_W     = 2;
   localparam int LIGHT_W      = 4;
   localparam int SHADE_W      = 8;
   localparam int AO_W         = 9;
   localparam int LIGHT_OUT_W  = 12;

   localparam logic [VOXEL_W-1:0]     CENTRE_VOXEL = 5'd13;
   localparam logic [LIGHT_W-1:0]     LIGHT_MAX    = 4'd15;
   localparam logic [FACE_W-1:0]      LAST_FACE    = 3'd5;
   localparam logic [AO_W-1:0]        AO_ONE       = 9'd256;
   localparam logic [LIGHT_OUT_W-1:0] FULL_LIGHT   = 12'd2560;
   // floor(l * 64 / 15) == (l * 4370) >> 10 for l in 0..60
   localparam logic [12:0]            LIGHT_RECIP  = 13'd4370;
   localparam int                     LIGHT_SHIFT  = 10;

   // request and response stream word widths
   localparam int REQ_DATA_W = 352;
   localparam int RSP_DATA_W = 88;

   typedef struct packed {
      logic [NUM_VOXELS-1:0][SHADE_W-1:0] shade;
      logic [NUM_VOXELS-1:0][LIGHT_W-1:0] light;
      logic [NUM_VOXELS-1:0]              solid;
   } nbhd_type;

   typedef struct packed {
      logic [LIGHT_OUT_W-1:0] light;
      logic [AO_W-1:0]        ao;
   } corner_type;

   // corner voxel, then the two side voxels
   localparam logic [VOXEL_W-1:0] SIDE_TAB [NUM_FACES][NUM_CORNERS][3] = '{
      '{'{5'd0,  5'd1,  5'd3},  '{5'd2,  5'd1,  5'd5},
        '{5'd6,  5'd3,  5'd7},  '{5'd8,  5'd5,  5'd7}},
      '{'{5'd18, 5'd19, 5'd21}, '{5'd20, 5'd19, 5'd23},
        '{5'd24, 5'd21, 5'd25}, '{5'd26, 5'd23, 5'd25}},
      '{'{5'd6,  5'd7,  5'd15}, '{5'd8,  5'd7,  5'd17},
        '{5'd24, 5'd15, 5'd25}, '{5'd26, 5'd17, 5'd25}},
      '{'{5'd0,  5'd1,  5'd9},  '{5'd2,  5'd1,  5'd11},
        '{5'd18, 5'd9,  5'd19}, '{5'd20, 5'd11, 5'd19}},
      '{'{5'd0,  5'd3,  5'd9},  '{5'd6,  5'd3,  5'd15},
        '{5'd18, 5'd9,  5'd21}, '{5'd24, 5'd15, 5'd21}},
      '{'{5'd2,  5'd5,  5'd11}, '{5'd8,  5'd5,  5'd17},
        '{5'd20, 5'd11, 5'd23}, '{5'd26, 5'd17, 5'd23}}
   };

   // the 2x2 group of voxels smoothed into each corner
   localparam logic [VOXEL_W-1:0] QUAD_TAB [NUM_FACES][NUM_CORNERS][4] = '{
      '{'{5'd0,  5'd1,  5'd3,  5'd4},  '{5'd1,  5'd2,  5'd4,  5'd5},
        '{5'd3,  5'd4,  5'd6,  5'd7},  '{5'd4,  5'd5,  5'd7,  5'd8}},
      '{'{5'd18, 5'd19, 5'd21, 5'd22}, '{5'd19, 5'd20, 5'd22, 5'd23},
        '{5'd21, 5'd22, 5'd24, 5'd25}, '{5'd22, 5'd23, 5'd25, 5'd26}},
      '{'{5'd6,  5'd7,  5'd15, 5'd16}, '{5'd7,  5'd8,  5'd16, 5'd17},
        '{5'd15, 5'd16, 5'd24, 5'd25}, '{5'd16, 5'd17, 5'd25, 5'd26}},
      '{'{5'd0,  5'd1,  5'd9,  5'd10}, '{5'd1,  5'd2,  5'd10, 5'd11},
        '{5'd9,  5'd10, 5'd18, 5'd19}, '{5'd10, 5'd11, 5'd19, 5'd20}},
      '{'{5'd0,  5'd3,  5'd9,  5'd12}, '{5'd3,  5'd6,  5'd12, 5'd15},
        '{5'd9,  5'd12, 5'd18, 5'd21}, '{5'd12, 5'd15, 5'd21, 5'd24}},
      '{'{5'd2,  5'd5,  5'd11, 5'd14}, '{5'd5,  5'd8,  5'd14, 5'd17},
        '{5'd11, 5'd14, 5'd20, 5'd23}, '{5'd14, 5'd17, 5'd23, 5'd26}}
   };

endpackage

// ----- rtl/core/vfao_corner.sv -----
// ---------------------------------------------------------------------------
// vfao_corner
// occlusion shade and smoothed light of one corner of the selected face
// ---------------------------------------------------------------------------
module vfao_corner import vfao_pkg::*; #(
   parameter int SHADE_FRAC_BITS = 8
) (
   input  nbhd_type              nbhd,
   input  logic [FACE_W-1:0]     face,
   input  logic [CORNER_W-1:0]   corner,
   output corner_type            result
);

   logic [VOXEL_W-1:0] side_idx [3];
   logic [VOXEL_W-1:0] quad_idx [4];
   logic               cor_bit;
   logic               side1_bit;
   logic               side2_bit;
   logic [1:0]         level;
   logic [9:0]         shade_total;
   logic [17:0]        shade_scaled;
   logic [17:0]        shade_term;
   logic [18:0]        ao_sum;
   logic [5:0]         light_total;
   logic [18:0]        light_prod;
   logic               full_light;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         side_idx[k] = SIDE_TAB[face][corner][k];
      end
      for (int k = 0; k < 4; k++) begin
         quad_idx[k] = QUAD_TAB[face][corner][k];
      end
   end

   assign cor_bit   = nbhd.solid[side_idx[0]];
   assign side1_bit = nbhd.solid[side_idx[1]];
   assign side2_bit = nbhd.solid[side_idx[2]];

   // both sides solid closes the corner fully
   assign level = (side1_bit && side2_bit) ? 2'd3 :
                  2'({1'b0, cor_bit} + {1'b0, side1_bit} + {1'b0, side2_bit});

   assign shade_total = 10'(nbhd.shade[quad_idx[0]]) + 10'(nbhd.shade[quad_idx[1]])
                      + 10'(nbhd.shade[quad_idx[2]]) + 10'(nbhd.shade[quad_idx[3]]);

   // average of four shades, rescaled to eight fraction bits
   assign shade_scaled = {shade_total, 8'd0};
   assign shade_term   = shade_scaled >> (SHADE_FRAC_BITS + 2);
   assign ao_sum       = 19'({level, 6'd0}) + 19'(shade_term);

   assign light_total = 6'(nbhd.light[quad_idx[0]]) + 6'(nbhd.light[quad_idx[1]])
                      + 6'(nbhd.light[quad_idx[2]]) + 6'(nbhd.light[quad_idx[3]]);
   assign light_prod = 19'(light_total) * 19'(LIGHT_RECIP);
   assign full_light = (nbhd.light[CENTRE_VOXEL] == LIGHT_MAX);

   always_comb begin
      result.ao    = (ao_sum > 19'(AO_ONE)) ? AO_ONE : ao_sum[AO_W-1:0];
      result.light = full_light ? FULL_LIGHT
                                : LIGHT_OUT_W'(light_prod[18:LIGHT_SHIFT]);
   end

endmodule

// ----- rtl/core/voxel_face_ambient_occlusion_unit.sv -----
// ---------------------------------------------------------------------------
// voxel_face_ambient_occlusion_unit
// per-vertex ambient occlusion and smooth light for the six faces of a voxel
// ---------------------------------------------------------------------------
//
//  channel   direction  tdata                          tlast       tuser
//  req_      in         3x3x3 neighbourhood, 351 bits  -           -
//  rsp_      out        face index, 4 ao, 4 light      last face   -
//
//  each neighbourhood gives six face results, one per cycle while rsp_ is not
//  stalled, computed by the four corner calculators stepping through the faces
//  the next neighbourhood is taken in the cycle the sixth face is computed,
//  so items follow each other without a gap
//  a stalled rsp_ side holds the result register and the face counter
//  synchronous active-high reset clears the valid flags and the face counter
//
module voxel_face_ambient_occlusion_unit import vfao_pkg::*; #(
   parameter int SHADE_FRAC_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // neighbor_solid[26:0], light_levels_low[82:27], light_levels_high[134:83],
   // shade_levels_a[198:135], shade_levels_b[262:199],
   // shade_levels_c[326:263], shade_levels_d[350:327], zero pad[351]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // face_index[2:0], ao_corner_0[11:3], ao_corner_1[20:12],
   // ao_corner_2[29:21], ao_corner_3[38:30], light_corner_0[50:39],
   // light_corner_1[62:51], light_corner_2[74:63], light_corner_3[86:75],
   // zero pad[87]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   // held neighbourhood and face sequencing
   nbhd_type            nbhd_ff;
   logic                item_valid_ff;
   logic                item_valid_in;
   logic [FACE_W-1:0]   face_ff;
   logic [FACE_W-1:0]   face_in;

   // result register
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [FACE_W-1:0]   rsp_face_ff;
   logic                rsp_last_ff;
   corner_type          rsp_corner_ff [NUM_CORNERS];

   corner_type          corner_res [NUM_CORNERS];
   logic                advance;
   logic                last_step;
   logic                req_accept;

   // a face is computed whenever an item is held and the result slot is free or being taken
   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign last_step  = advance && (face_ff == LAST_FACE);
   assign req_tready = !item_valid_ff || last_step;
   assign req_accept = req_tvalid && req_tready;

   // one calculator per corner, all sharing the current face
   for (genvar c = 0; c < NUM_CORNERS; c++) begin : g_corner
      vfao_corner #(
         .SHADE_FRAC_BITS (SHADE_FRAC_BITS)
      ) u_corner (
         .nbhd   (nbhd_ff),
         .face   (face_ff),
         .corner (CORNER_W'(c)),
         .result (corner_res[c])
      );
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      face_in       = face_ff;
      if (advance) begin
         face_in = last_step ? '0 : face_ff + 1'b1;
      end
      if (last_step) begin
         item_valid_in = 1'b0;
      end
      if (req_accept) begin
         item_valid_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         face_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         face_ff       <= face_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         nbhd_ff.solid <= req_tdata[26:0];
         nbhd_ff.light <= req_tdata[134:27];
         nbhd_ff.shade <= req_tdata[350:135];
      end
      if (advance) begin
         rsp_face_ff <= face_ff;
         rsp_last_ff <= (face_ff == LAST_FACE);
         for (int c = 0; c < NUM_CORNERS; c++) begin
            rsp_corner_ff[c] <= corner_res[c];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {1'b0,
                        rsp_corner_ff[3].light, rsp_corner_ff[2].light,
                        rsp_corner_ff[1].light, rsp_corner_ff[0].light,
                        rsp_corner_ff[3].ao,    rsp_corner_ff[2].ao,
                        rsp_corner_ff[1].ao,    rsp_corner_ff[0].ao,
                        rsp_face_ff};

endmodule
